FILE: rtl/vlan_header_parser_macros.svh
// Assertion macros for the VLAN header parser.
// No dependencies; included by the files that carry assertions.
`ifndef VLAN_HEADER_PARSER_MACROS_SVH
`define VLAN_HEADER_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge out of reset.
`define VHP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Expression must never be true out of reset.
`define VHP_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define VHP_ASSERT(lbl, clk, rstn, prop, msg)
`define VHP_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

FILE: rtl/vhp_pkg.sv
// Shared types, codes and constants of the VLAN header parser.
// No dependencies; used by every module of the block.
`default_nettype none

package vhp_pkg;

    // Tag limit per frame.
    localparam int unsigned MAX_TAGS = 2;

    localparam int POS_W     = 6;
    localparam int TAG_CNT_W = 4;
    localparam int MAC_W     = 48;
    localparam int WORD_W    = 16;
    localparam int SHIFT_W   = 32;

    // Byte positions within the header.
    localparam logic [POS_W-1:0] POS_MAX        = 6'd63;
    localparam logic [POS_W-1:0] DEST_LAST_POS  = 6'd5;
    localparam logic [POS_W-1:0] MAC_LAST_POS   = 6'd11;
    localparam logic [POS_W-1:0] MAC_HDR_LEN    = 6'd12;
    localparam logic [POS_W-1:0] MIN_FRAME_LAST = 6'd13;

    // Tag protocol identifiers.
    localparam logic [WORD_W-1:0] TPID_CTAG = 16'h8100;
    localparam logic [WORD_W-1:0] TPID_STAG = 16'h88A8;
    localparam logic [WORD_W-1:0] TPID_ITAG = 16'h88E7;

    // Result kinds.
    localparam logic KIND_TAG     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Queue between front and back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_TAG_LIMIT = 2'd2,
        ST_TRUNC     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_MAC  = 4'b0001,
        PH_TYPE = 4'b0010,
        PH_TCI  = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    // One queue entry: everything the back end needs for the results of one item.
    typedef struct packed {
        logic                 has_tag;
        logic                 has_sum;
        logic [MAC_W-1:0]     dest;
        logic [MAC_W-1:0]     src;
        logic [WORD_W-1:0]    tpid;
        logic [WORD_W-1:0]    tci;
        logic [WORD_W-1:0]    etype;
        logic [TAG_CNT_W-1:0] tags;
        logic [POS_W-1:0]     poff;
        status_t              status;
    } record_t;

    function automatic logic tpid_match(input logic [WORD_W-1:0] w);
        return (w == TPID_CTAG) || (w == TPID_STAG) || (w == TPID_ITAG);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/vhp_front.sv
// Front end: accepts frame bytes, tracks the header parse and builds result records.
// Depends on vhp_pkg.
`default_nettype none

module vhp_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_data_byte,
    input  wire logic             s_frame_end,
    input  wire logic             fifo_full,
    output logic                  push,
    output vhp_pkg::record_t      push_rec
);

    logic [vhp_pkg::POS_W-1:0]     pos_reg,   pos_next;
    vhp_pkg::phase_t               phase_reg, phase_next;
    logic [vhp_pkg::MAC_W-1:0]     dest_reg,  dest_next;
    logic [vhp_pkg::MAC_W-1:0]     src_reg,   src_next;
    logic [vhp_pkg::SHIFT_W-1:0]   shift_reg, shift_next;
    logic [vhp_pkg::TAG_CNT_W-1:0] tags_reg,  tags_next;
    logic [vhp_pkg::WORD_W-1:0]    type_reg,  type_next;
    logic [vhp_pkg::POS_W-1:0]     poff_reg,  poff_next;
    vhp_pkg::status_t              stat_reg,  stat_next;

    logic                          accept;
    logic                          tag_done;
    logic                          short_frame;
    logic [vhp_pkg::SHIFT_W-1:0]   shifted;
    logic [vhp_pkg::POS_W-1:0]     pos_inc;

    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;
    assign shifted = {shift_reg[vhp_pkg::SHIFT_W-9:0], s_data_byte};
    assign pos_inc = pos_reg + 6'd1;

    // Parse step for the current byte.
    always_comb begin
        phase_next = phase_reg;
        dest_next  = dest_reg;
        src_next   = src_reg;
        shift_next = shift_reg;
        tags_next  = tags_reg;
        type_next  = type_reg;
        poff_next  = poff_reg;
        stat_next  = stat_reg;
        tag_done   = 1'b0;
        unique case (phase_reg)
            vhp_pkg::PH_MAC: begin
                if (pos_reg <= vhp_pkg::DEST_LAST_POS) begin
                    dest_next = {dest_reg[vhp_pkg::MAC_W-9:0], s_data_byte};
                end else begin
                    src_next = {src_reg[vhp_pkg::MAC_W-9:0], s_data_byte};
                end
                if (pos_reg >= vhp_pkg::MAC_LAST_POS) begin
                    phase_next = vhp_pkg::PH_TYPE;
                    poff_next  = vhp_pkg::MAC_HDR_LEN;
                end
            end
            vhp_pkg::PH_TYPE: begin
                shift_next = shifted;
                if (pos_reg[0]) begin
                    if (vhp_pkg::tpid_match(shifted[vhp_pkg::WORD_W-1:0])) begin
                        phase_next = vhp_pkg::PH_TCI;
                    end else begin
                        type_next  = shifted[vhp_pkg::WORD_W-1:0];
                        poff_next  = pos_inc;
                        stat_next  = vhp_pkg::ST_OK;
                        phase_next = vhp_pkg::PH_DONE;
                    end
                end
            end
            vhp_pkg::PH_TCI: begin
                shift_next = shifted;
                if (pos_reg[0]) begin
                    tag_done  = 1'b1;
                    tags_next = tags_reg + 4'd1;
                    poff_next = pos_inc;
                    if (tags_next >= vhp_pkg::TAG_CNT_W'(vhp_pkg::MAX_TAGS)) begin
                        stat_next  = vhp_pkg::ST_TAG_LIMIT;
                        phase_next = vhp_pkg::PH_DONE;
                    end else begin
                        phase_next = vhp_pkg::PH_TYPE;
                    end
                end
            end
            vhp_pkg::PH_DONE: begin
                phase_next = phase_reg;
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
        pos_next = (pos_reg == vhp_pkg::POS_MAX) ? pos_reg : pos_inc;
    end

    // Record for the queue; the summary fields use the state after this byte.
    assign short_frame = pos_reg < vhp_pkg::MIN_FRAME_LAST;
    assign push        = accept && (tag_done || s_frame_end);

    always_comb begin
        push_rec.has_tag = tag_done;
        push_rec.has_sum = s_frame_end;
        push_rec.dest    = short_frame ? '0 : dest_next;
        push_rec.src     = short_frame ? '0 : src_next;
        push_rec.tpid    = shifted[vhp_pkg::SHIFT_W-1:vhp_pkg::WORD_W];
        push_rec.tci     = shifted[vhp_pkg::WORD_W-1:0];
        push_rec.etype   = short_frame ? '0 : type_next;
        push_rec.tags    = short_frame ? '0 : tags_next;
        push_rec.poff    = short_frame ? '0 : poff_next;
        push_rec.status  = short_frame ? vhp_pkg::ST_SHORT : stat_next;
    end

    // Parse state; the end of a frame returns it to the reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_frame_end)) begin
            pos_reg   <= '0;
            phase_reg <= vhp_pkg::PH_MAC;
            dest_reg  <= '0;
            src_reg   <= '0;
            shift_reg <= '0;
            tags_reg  <= '0;
            type_reg  <= '0;
            poff_reg  <= '0;
            stat_reg  <= vhp_pkg::ST_TRUNC;
        end else if (accept) begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            dest_reg  <= dest_next;
            src_reg   <= src_next;
            shift_reg <= shift_next;
            tags_reg  <= tags_next;
            type_reg  <= type_next;
            poff_reg  <= poff_next;
            stat_reg  <= stat_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/vhp_fifo.sv
// Short queue of result records between the front and back ends.
// Depends on vhp_pkg.
`default_nettype none

module vhp_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  vhp_pkg::record_t       push_rec,
    input  wire logic              pop,
    output vhp_pkg::record_t       rd_rec,
    output logic                   full,
    output logic                   empty
);

    vhp_pkg::record_t                mem [vhp_pkg::FIFO_DEPTH];
    logic [vhp_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [vhp_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [vhp_pkg::FIFO_CNT_W-1:0]  count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign full    = count_reg == vhp_pkg::FIFO_CNT_W'(vhp_pkg::FIFO_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_rec  = mem[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/vhp_back.sv
// Back end: presents queued records' results one per cycle while m_ready is high.
// Depends on vhp_pkg.
`default_nettype none

module vhp_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             fifo_empty,
    output logic                  pop,
    input  vhp_pkg::record_t      rd_rec,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_kind,
    output logic                  m_last,
    output logic [47:0]           m_dest_mac,
    output logic [47:0]           m_src_mac,
    output logic [15:0]           m_tag_tpid,
    output logic [2:0]            m_priority_res,
    output logic                  m_drop_eligible,
    output logic [11:0]           m_vlan_id,
    output logic [15:0]           m_ether_type,
    output logic [3:0]            m_tags_found,
    output logic [5:0]            m_payload_start,
    output logic [1:0]            m_status
);

    vhp_pkg::record_t rec_reg;
    logic             tag_pend_reg, tag_pend_next;
    logic             sum_pend_reg, sum_pend_next;
    logic             out_done;

    assign m_valid  = tag_pend_reg || sum_pend_reg;
    assign m_last   = tag_pend_reg ? !sum_pend_reg : 1'b1;
    assign out_done = !m_valid || (m_ready && m_last);
    assign pop      = out_done && !fifo_empty;

    // Tag result first, then the summary, from the held record.
    always_comb begin
        tag_pend_next = tag_pend_reg;
        sum_pend_next = sum_pend_reg;
        if (pop) begin
            tag_pend_next = rd_rec.has_tag;
            sum_pend_next = rd_rec.has_sum;
        end else if (m_valid && m_ready) begin
            if (tag_pend_reg) begin
                tag_pend_next = 1'b0;
            end else begin
                sum_pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_pend_reg <= 1'b0;
            sum_pend_reg <= 1'b0;
        end else begin
            tag_pend_reg <= tag_pend_next;
            sum_pend_reg <= sum_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            rec_reg <= rd_rec;
        end
    end

    // Result fields; tag and summary fields are zero in the other kind.
    always_comb begin
        m_kind          = tag_pend_reg ? vhp_pkg::KIND_TAG : vhp_pkg::KIND_SUMMARY;
        m_dest_mac      = rec_reg.dest;
        m_src_mac       = rec_reg.src;
        m_tags_found    = rec_reg.tags;
        m_payload_start = rec_reg.poff;
        if (tag_pend_reg) begin
            m_tag_tpid      = rec_reg.tpid;
            m_priority_res  = rec_reg.tci[15:13];
            m_drop_eligible = rec_reg.tci[12];
            m_vlan_id       = rec_reg.tci[11:0];
            m_ether_type    = '0;
            m_status        = vhp_pkg::ST_OK;
        end else begin
            m_tag_tpid      = '0;
            m_priority_res  = '0;
            m_drop_eligible = 1'b0;
            m_vlan_id       = '0;
            m_ether_type    = rec_reg.etype;
            m_status        = rec_reg.status;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/vlan_header_parser.sv
// VLAN header parser, top level: front end, record queue and back end.
// Depends on vhp_pkg, vhp_front, vhp_fifo, vhp_back and the assertion macro header.
//
// Usage: frame bytes enter on the s_ channel in wire order, one item per byte,
// with s_frame_end high on the final byte. Results leave on the m_ channel:
// a tag result (m_kind 0) once both bytes of a tag's control word are in, and
// a summary (m_kind 1) on the final byte. A byte causes at most two results;
// m_last marks the last of them.
// Throughput: one byte per cycle while s_ready is high. A byte that causes two results
// holds the output until both are taken; the two-entry queue absorbs this.
// Output path: the queue is written at the accepting edge and the back-end output
// register loads from it once the results of the previous record are taken, so every
// result is presented from that register, never straight from the queue.
// s_ready drops only when the queue is full, which happens when the receiver
// stalls m_ready while results keep arriving.
// Reset (aresetn low at a clock edge) empties the queue, drops any pending
// result and starts a new frame at the destination address.
`default_nettype none

`include "vlan_header_parser_macros.svh"

module vlan_header_parser (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_data_byte,
    input  wire logic         s_frame_end,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic              m_kind,
    output logic              m_last,
    output logic [47:0]       m_dest_mac,
    output logic [47:0]       m_src_mac,
    output logic [15:0]       m_tag_tpid,
    output logic [2:0]        m_priority_res,
    output logic              m_drop_eligible,
    output logic [11:0]       m_vlan_id,
    output logic [15:0]       m_ether_type,
    output logic [3:0]        m_tags_found,
    output logic [5:0]        m_payload_start,
    output logic [1:0]        m_status
);

    vhp_pkg::record_t push_rec;
    vhp_pkg::record_t rd_rec;
    logic             push;
    logic             pop;
    logic             fifo_full;
    logic             fifo_empty;

    vhp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_frame_end (s_frame_end),
        .fifo_full   (fifo_full),
        .push        (push),
        .push_rec    (push_rec)
    );

    vhp_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .rd_rec   (rd_rec),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    vhp_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .fifo_empty      (fifo_empty),
        .pop             (pop),
        .rd_rec          (rd_rec),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_last          (m_last),
        .m_dest_mac      (m_dest_mac),
        .m_src_mac       (m_src_mac),
        .m_tag_tpid      (m_tag_tpid),
        .m_priority_res  (m_priority_res),
        .m_drop_eligible (m_drop_eligible),
        .m_vlan_id       (m_vlan_id),
        .m_ether_type    (m_ether_type),
        .m_tags_found    (m_tags_found),
        .m_payload_start (m_payload_start),
        .m_status        (m_status)
    );

    // A summary always closes the results of its item.
    `VHP_ASSERT(a_summary_last, aclk, aresetn,
        (m_valid && m_kind == vhp_pkg::KIND_SUMMARY) |-> m_last,
        "summary result without last")
    // The tag count never passes the tag limit.
    `VHP_NEVER(a_tag_limit, aclk, aresetn,
        m_valid && (m_tags_found > 4'(vhp_pkg::MAX_TAGS)),
        "tag count beyond limit")
    // A tag result counts at least the tag it reports.
    `VHP_NEVER(a_tag_count, aclk, aresetn,
        m_valid && m_kind == vhp_pkg::KIND_TAG && m_tags_found == 4'd0,
        "tag result with zero tag count")
    // The front end never pushes into a full queue.
    `VHP_NEVER(a_no_overflow, aclk, aresetn,
        push && fifo_full,
        "record pushed into a full queue")

endmodule

`default_nettype wire

FILE: tb/vlan_header_parser_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for vlan_header_parser: frames go in byte by byte, and every
// tag result and frame summary is checked against a predictor kept here.
// Depends on vhp_pkg and the vlan_header_parser RTL.

module vlan_header_parser_test;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_END     = 1250;
    localparam int TOTAL_BYTES    = 1350;
    localparam int DRAIN_CYCLES   = 16;

    // One result as the m_ channel presents it.
    typedef struct packed {
        logic              kind;
        logic              last;
        logic [47:0]       dest;
        logic [47:0]       src;
        logic [15:0]       tpid;
        logic [2:0]        pcp;
        logic              dei;
        logic [11:0]       vid;
        logic [15:0]       etype;
        logic [3:0]        tags;
        logic [5:0]        poff;
        vhp_pkg::status_t  status;
    } hdr_result_t;

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [7:0]   s_data_byte = 8'h00;
    logic         s_frame_end = 1'b0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic         m_kind;
    logic         m_last;
    logic [47:0]  m_dest_mac;
    logic [47:0]  m_src_mac;
    logic [15:0]  m_tag_tpid;
    logic [2:0]   m_priority_res;
    logic         m_drop_eligible;
    logic [11:0]  m_vlan_id;
    logic [15:0]  m_ether_type;
    logic [3:0]   m_tags_found;
    logic [5:0]   m_payload_start;
    logic [1:0]   m_status;

    // Parser state as predicted from the accepted bytes.
    logic [5:0]        cur_pos;
    vhp_pkg::phase_t   cur_phase;
    logic [47:0]       dest_acc;
    logic [47:0]       src_acc;
    logic [31:0]       word_acc;
    logic [3:0]        tag_cnt;
    logic [15:0]       etype_acc;
    logic [5:0]        poff_acc;
    vhp_pkg::status_t  hdr_status;

    hdr_result_t  parsed_results[$];
    logic [7:0]   frame_buf[$];

    int  fail_count = 0;
    int  bytes_sent = 0;
    int  idle_pct = 20;
    int  stall_pct = 15;
    int  stall_left = 0;
    int  stall_epoch = 0;
    int  stuck_cycles = 0;
    bit  quiet = 1'b0;

    vlan_header_parser dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_frame_end     (s_frame_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_last          (m_last),
        .m_dest_mac      (m_dest_mac),
        .m_src_mac       (m_src_mac),
        .m_tag_tpid      (m_tag_tpid),
        .m_priority_res  (m_priority_res),
        .m_drop_eligible (m_drop_eligible),
        .m_vlan_id       (m_vlan_id),
        .m_ether_type    (m_ether_type),
        .m_tags_found    (m_tags_found),
        .m_payload_start (m_payload_start),
        .m_status        (m_status)
    );

    // 250 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Return the predicted parser to its start-of-frame state.
    function automatic void clear_parser();
        cur_pos    = '0;
        cur_phase  = vhp_pkg::PH_MAC;
        dest_acc   = '0;
        src_acc    = '0;
        word_acc   = '0;
        tag_cnt    = '0;
        etype_acc  = '0;
        poff_acc   = '0;
        hdr_status = vhp_pkg::ST_TRUNC;
    endfunction

    // Append one predicted result at the tail of the expected queue.
    function automatic void expect_result(input hdr_result_t r);
        parsed_results.insert(parsed_results.size(), r);
    endfunction

    // Append one byte at the end of the frame under construction.
    function automatic void append_byte(input logic [7:0] b);
        frame_buf.insert(frame_buf.size(), b);
    endfunction

    // Advance the predicted parser by one accepted byte and queue the results it causes.
    task automatic parse_byte(input logic [7:0] b, input logic fend);
        logic [5:0]   pos;
        logic [15:0]  w;
        hdr_result_t  r;
        pos = cur_pos;
        case (cur_phase)
            vhp_pkg::PH_MAC: begin
                if (pos <= vhp_pkg::DEST_LAST_POS) dest_acc = {dest_acc[39:0], b};
                else src_acc = {src_acc[39:0], b};
                if (pos >= vhp_pkg::MAC_LAST_POS) begin
                    cur_phase = vhp_pkg::PH_TYPE;
                    poff_acc = vhp_pkg::MAC_HDR_LEN;
                end
            end
            vhp_pkg::PH_TYPE: begin
                word_acc = {word_acc[23:0], b};
                if (pos[0]) begin
                    w = word_acc[15:0];
                    if (w == vhp_pkg::TPID_CTAG || w == vhp_pkg::TPID_STAG ||
                        w == vhp_pkg::TPID_ITAG) begin
                        cur_phase = vhp_pkg::PH_TCI;
                    end else begin
                        etype_acc  = w;
                        poff_acc   = pos + 6'd1;
                        hdr_status = vhp_pkg::ST_OK;
                        cur_phase  = vhp_pkg::PH_DONE;
                    end
                end
            end
            vhp_pkg::PH_TCI: begin
                word_acc = {word_acc[23:0], b};
                if (pos[0]) begin
                    tag_cnt  = tag_cnt + 4'd1;
                    poff_acc = pos + 6'd1;
                    r        = '0;
                    r.kind   = vhp_pkg::KIND_TAG;
                    r.last   = !fend;
                    r.dest   = dest_acc;
                    r.src    = src_acc;
                    r.tpid   = word_acc[31:16];
                    r.pcp    = word_acc[15:13];
                    r.dei    = word_acc[12];
                    r.vid    = word_acc[11:0];
                    r.tags   = tag_cnt;
                    r.poff   = poff_acc;
                    r.status = vhp_pkg::ST_OK;
                    expect_result(r);
                    if (tag_cnt >= vhp_pkg::MAX_TAGS) begin
                        hdr_status = vhp_pkg::ST_TAG_LIMIT;
                        cur_phase  = vhp_pkg::PH_DONE;
                    end else begin
                        cur_phase = vhp_pkg::PH_TYPE;
                    end
                end
            end
            default: ;
        endcase
        if (cur_pos != vhp_pkg::POS_MAX) cur_pos = cur_pos + 6'd1;

        // The final byte adds the frame summary; a frame under 14 bytes reports only its status.
        if (fend) begin
            r = '0;
            r.kind = vhp_pkg::KIND_SUMMARY;
            r.last = 1'b1;
            if (pos < vhp_pkg::MIN_FRAME_LAST) begin
                r.status = vhp_pkg::ST_SHORT;
            end else begin
                r.dest   = dest_acc;
                r.src    = src_acc;
                r.etype  = etype_acc;
                r.tags   = tag_cnt;
                r.poff   = poff_acc;
                r.status = hdr_status;
            end
            expect_result(r);
            clear_parser();
        end
    endtask

    // Offer one byte, with an occasional idle burst first, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic fend);
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_frame_end <= fend;
        do @(posedge aclk); while (!s_ready);
        parse_byte(b, fend);
        bytes_sent++;
    endtask

    // Send the first len bytes of frame_buf as one frame.
    task automatic send_frame(input int len);
        int i;
        for (i = 0; i < len; i++) send_byte(frame_buf[i], i == len - 1);
    endtask

    // Lay out a frame in frame_buf: addresses, tags with random TCI, a type word, payload.
    // A negative tpid_sel picks each tag's TPID at random, otherwise they rotate from it.
    task automatic build_frame(input logic [47:0] dst, input logic [47:0] src,
                               input int n_tags, input int tpid_sel,
                               input logic [15:0] etype, input int payload_len);
        int          i;
        int          sel;
        logic [15:0] tpid;
        logic [31:0] rnd;
        frame_buf.delete();
        for (i = 5; i >= 0; i--) append_byte(dst[i*8 +: 8]);
        for (i = 5; i >= 0; i--) append_byte(src[i*8 +: 8]);
        for (i = 0; i < n_tags; i++) begin
            sel = (tpid_sel < 0) ? int'($urandom_range(0, 2)) : (tpid_sel + i) % 3;
            case (sel)
                0: tpid = vhp_pkg::TPID_CTAG;
                1: tpid = vhp_pkg::TPID_STAG;
                default: tpid = vhp_pkg::TPID_ITAG;
            endcase
            rnd = $urandom;
            append_byte(tpid[15:8]);
            append_byte(tpid[7:0]);
            append_byte(rnd[15:8]);
            append_byte(rnd[7:0]);
        end
        append_byte(etype[15:8]);
        append_byte(etype[7:0]);
        for (i = 0; i < payload_len; i++) begin
            rnd = $urandom;
            append_byte(rnd[7:0]);
        end
    endtask

    // Frames under the minimum length: a single byte and one byte short of a full header.
    task automatic test_short_frames();
        build_frame('1, '0, 0, 0, 16'hFFFF, 0);
        send_frame(1);
        build_frame('0, '1, 0, 0, 16'hFFFF, 0);
        send_frame(13);
    endtask

    // Untagged frames: exactly 14 bytes, and one with payload after the EtherType.
    task automatic test_untagged_frames();
        build_frame('1, '0, 0, 0, 16'hFFFF, 0);
        send_frame(14);
        build_frame('0, '1, 0, 0, 16'h0000, 3);
        send_frame(frame_buf.size());
    endtask

    // A frame that ends on the last TCI byte gives a tag result and a summary from one item.
    task automatic test_tag_on_final_byte();
        build_frame(48'h0123_4567_89AB, 48'hFEDC_BA98_7654, 1, 0, 16'h0800, 0);
        send_frame(16);
    endtask

    // Tag limit reached: the following type word, even a TPID, is left unparsed.
    task automatic test_tag_limit();
        build_frame('0, '0, vhp_pkg::MAX_TAGS, 1, 16'h86DD, 2);
        send_frame(frame_buf.size());
        build_frame('1, '1, vhp_pkg::MAX_TAGS, 2, vhp_pkg::TPID_CTAG, 4);
        send_frame(frame_buf.size());
    endtask

    // Frames cut after the TPID, after one EtherType byte, and with both EtherType bytes.
    task automatic test_truncated_frames();
        build_frame(48'hA5A5_A5A5_A5A5, 48'h5A5A_5A5A_5A5A, 1, 2, 16'h0800, 0);
        send_frame(14);
        send_frame(17);
        send_frame(18);
    endtask

    // Frames past 63 bytes, where the byte count saturates.
    task automatic test_long_frames();
        build_frame(48'h0000_0000_0001, 48'h8000_0000_0000, 0, 0, 16'h0800, 50);
        send_frame(64);
        build_frame(48'h0800_2000_0000, 48'h0000_0000_0000, 1, 1, 16'h8101, 62);
        send_frame(frame_buf.size());
    endtask

    // Random frame: mostly well-formed headers with random content, some cut short,
    // some pure noise.
    task automatic send_random_frame();
        int           pick;
        int           n_tags;
        int           payload;
        int           len;
        int           i;
        logic [63:0]  rnd64;
        logic [47:0]  dst;
        logic [47:0]  src;
        logic [15:0]  etype;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            frame_buf.delete();
            len = $urandom_range(1, 30);
            for (i = 0; i < len; i++) begin
                rnd64[31:0] = $urandom;
                append_byte(rnd64[7:0]);
            end
            send_frame(len);
        end else begin
            rnd64 = {$urandom, $urandom};
            dst = (pick < 15) ? '1 : (pick < 20) ? '0 : rnd64[47:0];
            rnd64 = {$urandom, $urandom};
            src = (pick > 94) ? '1 : (pick > 89) ? '0 : rnd64[47:0];
            rnd64[31:0] = $urandom;
            case ($urandom_range(0, 4))
                0: etype = 16'h8101;
                1: etype = 16'h88A9;
                2: etype = 16'h0800;
                default: etype = rnd64[15:0];
            endcase
            n_tags  = $urandom_range(0, vhp_pkg::MAX_TAGS + 1);
            payload = ($urandom_range(0, 29) == 0) ? int'($urandom_range(40, 60))
                                                   : int'($urandom_range(0, 12));
            build_frame(dst, src, n_tags, -1, etype, payload);
            len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, frame_buf.size()))
                                              : frame_buf.size();
            send_frame(len);
        end
    endtask

    // Random frames with varying idle pressure on the input side.
    task automatic test_random_frames();
        while (bytes_sent < RANDOM_END) begin
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 35;
            endcase
            send_random_frame();
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_back_to_back();
        quiet = 1'b1;
        while (bytes_sent < TOTAL_BYTES) send_random_frame();
    endtask

    function automatic string fmt_result(input hdr_result_t r);
        return {$sformatf("kind=%0d last=%0d dst=%h src=%h tpid=%h pcp=%0d dei=%0d ",
                          r.kind, r.last, r.dest, r.src, r.tpid, r.pcp, r.dei),
                $sformatf("vid=%h etype=%h tags=%0d poff=%0d status=%0d",
                          r.vid, r.etype, r.tags, r.poff, r.status)};
    endfunction

    // Receiver stalls in bursts of random length; the stall rate is redrawn as stall_epoch advances.
    always @(posedge aclk) begin
        stall_epoch++;
        if (stall_epoch % 50 == 0) begin
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 15;
                default: stall_pct = 40;
            endcase
        end
        if (quiet) begin
            m_ready <= 1'b1;
            stall_left = 0;
        end else if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest one predicted.
    always @(posedge aclk) begin : result_check
        hdr_result_t got;
        hdr_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.kind   = m_kind;
            got.last   = m_last;
            got.dest   = m_dest_mac;
            got.src    = m_src_mac;
            got.tpid   = m_tag_tpid;
            got.pcp    = m_priority_res;
            got.dei    = m_drop_eligible;
            got.vid    = m_vlan_id;
            got.etype  = m_ether_type;
            got.tags   = m_tags_found;
            got.poff   = m_payload_start;
            got.status = vhp_pkg::status_t'(m_status);
            if (parsed_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result: %s", $realtime, fmt_result(got));
            end else begin
                want = parsed_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                 $realtime, fmt_result(want), fmt_result(got));
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either channel ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item accepted for %0d cycles", $realtime, WATCHDOG_LIMIT);
                $display("vlan_header_parser regression: fail");
                $finish;
            end
        end
    end

    // Reset, run every test in turn, drain, and report.
    initial begin
        clear_parser();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_short_frames();
        test_untagged_frames();
        test_tag_on_final_byte();
        test_tag_limit();
        test_truncated_frames();
        test_long_frames();
        test_random_frames();
        test_back_to_back();
        s_valid <= 1'b0;
        while (parsed_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("vlan_header_parser regression: pass");
        end else begin
            $display("vlan_header_parser regression: fail");
        end
        $finish;
    end

endmodule
